// ===== design/square_matrix_add_sub_mul_unit_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the square matrix add, subtract and multiply unit.
// Each macro checks one property on the rising edge of clk, off during reset.
// ---------------------------------------------------------------------------
`ifndef SQUARE_MATRIX_ADD_SUB_MUL_UNIT_MACROS_SVH
`define SQUARE_MATRIX_ADD_SUB_MUL_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SMASM_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("smasm: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define SMASM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("smasm: next-cycle check failed");

`endif

// ===== design/smasm_pkg.sv =====
// ---------------------------------------------------------------------------
// smasm_pkg
// Shared widths, register indexes, mode codes and types of the matrix unit.
// ---------------------------------------------------------------------------
package smasm_pkg;

  localparam int MAX_DIM    = 8;
  localparam int CELLS      = MAX_DIM * MAX_DIM;
  localparam int IDX_W      = $clog2(CELLS);
  localparam int CNT_W      = $clog2(CELLS + 1);
  localparam int POS_W      = 3;
  localparam int DIM_W      = 4;
  localparam int MODE_W     = 2;
  localparam int CFG_DATA_W = 4;
  localparam int CFG_IDX_W  = 1;
  localparam int ELEM_W     = 16;
  localparam int TERM_W     = 2 * ELEM_W + 1;
  localparam int VAL_W      = 35;

  localparam logic [CFG_IDX_W-1:0] REG_DIMENSION = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_MODE      = 1'b1;

  localparam logic [MODE_W-1:0] MODE_SUM  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_DIFF = 2'd1;
  localparam logic [MODE_W-1:0] MODE_PROD = 2'd2;

  localparam logic [DIM_W-1:0] DIM_RESET = 4'd8;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_RUN   = 3'b010,
    ST_DRAIN = 3'b100
  } state_t;

  typedef struct packed {
    logic             valid;
    logic             first;
    logic             last_k;
    logic             last_mat;
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
  } pipe_tag_t;

endpackage

// ===== design/square_matrix_add_sub_mul_unit.sv =====
// ---------------------------------------------------------------------------
// square_matrix_add_sub_mul_unit
// Loads two square matrices word by word and streams out A+B, A-B or A*B.
// ---------------------------------------------------------------------------
// An input word is taken at a clock edge with start high and busy low. It
// carries one element and the matrix it belongs to; each matrix fills in
// row-major order and ignores words once it holds dimension squared elements.
// The word that leaves both matrices full starts the output pass: busy rises
// and the result matrix leaves in row-major order, one word per out_strobe
// cycle, with out_last_of_matrix on the final one. The receiver cannot stall,
// so nothing waits on it.
// One multiply-accumulate unit fed by one read port per matrix store sets the
// pass length: the product sums dimension terms for each result element,
// and the sum or difference takes a single term for each.
// Configuration is to be written on the cfg port only while busy is low; the
// block does not enforce this. Reset sets the dimension to eight, the mode to
// sum and both fill counts to zero; the matrix stores are not cleared.
// ---------------------------------------------------------------------------
module square_matrix_add_sub_mul_unit (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  logic                                 in_target_is_b,
  input  logic signed [smasm_pkg::ELEM_W-1:0]  in_element_value,
  output logic                                 out_strobe,
  output logic signed [smasm_pkg::VAL_W-1:0]   out_result_value,
  output logic [smasm_pkg::POS_W-1:0]          out_result_row,
  output logic [smasm_pkg::POS_W-1:0]          out_result_column,
  output logic                                 out_last_of_matrix,
  input  logic                                 cfg_we,
  input  logic [smasm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [smasm_pkg::CFG_DATA_W-1:0]     cfg_data
);

  smasm_pkg::state_t                  state_r, state_nxt;
  logic [smasm_pkg::DIM_W-1:0]        dimension_r;
  logic [smasm_pkg::MODE_W-1:0]       mode_r;
  logic [smasm_pkg::CNT_W-1:0]        cnt_a_r, cnt_a_nxt, cnt_b_r, cnt_b_nxt;
  logic [smasm_pkg::POS_W-1:0]        row_r, row_nxt, col_r, col_nxt, k_r, k_nxt;
  smasm_pkg::pipe_tag_t               tag0, tag1_r, tag2_r;
  logic signed [smasm_pkg::TERM_W-1:0] term_r, term_nxt;
  logic signed [smasm_pkg::VAL_W-1:0] acc_r, acc_sum;
  logic                               out_strobe_r;
  logic signed [smasm_pkg::VAL_W-1:0] out_value_r;
  logic [smasm_pkg::POS_W-1:0]        out_row_r, out_col_r;
  logic                               out_last_r;

  logic [smasm_pkg::DIM_W-1:0]        dim_n;
  logic [smasm_pkg::CNT_W-1:0]        total;
  logic [smasm_pkg::POS_W-1:0]        last_pos, k_end;
  logic                               is_prod, is_diff;
  logic                               accept, we_a, we_b;
  logic [smasm_pkg::CNT_W-1:0]        cnt_a_upd, cnt_b_upd;
  logic [2*smasm_pkg::DIM_W-1:0]      row_base, k_base;
  logic [smasm_pkg::IDX_W-1:0]        raddr_a, raddr_b;
  logic signed [smasm_pkg::ELEM_W-1:0] rdata_a, rdata_b;
  logic signed [2*smasm_pkg::ELEM_W-1:0] product;
  logic signed [smasm_pkg::ELEM_W:0]   sum_diff;
  logic signed [smasm_pkg::VAL_W-1:0]  acc_base;

  // Clamp the dimension to the supported range.
  always_comb begin
    if (dimension_r == '0) begin
      dim_n = smasm_pkg::DIM_W'(1);
    end else if (dimension_r > smasm_pkg::DIM_W'(smasm_pkg::MAX_DIM)) begin
      dim_n = smasm_pkg::DIM_W'(smasm_pkg::MAX_DIM);
    end else begin
      dim_n = dimension_r;
    end
  end

  assign total    = smasm_pkg::CNT_W'(dim_n * dim_n);
  assign last_pos = smasm_pkg::POS_W'(dim_n - smasm_pkg::DIM_W'(1));
  assign is_prod  = mode_r[1];
  assign is_diff  = (mode_r == smasm_pkg::MODE_DIFF);
  assign k_end    = is_prod ? last_pos : '0;

  assign busy   = (state_r != smasm_pkg::ST_IDLE);
  assign accept = start && !busy;
  assign we_a   = accept && !in_target_is_b && (cnt_a_r < total);
  assign we_b   = accept && in_target_is_b && (cnt_b_r < total);

  assign cnt_a_upd = we_a ? cnt_a_r + smasm_pkg::CNT_W'(1) : cnt_a_r;
  assign cnt_b_upd = we_b ? cnt_b_r + smasm_pkg::CNT_W'(1) : cnt_b_r;

  always_comb begin
    state_nxt = state_r;
    cnt_a_nxt = cnt_a_r;
    cnt_b_nxt = cnt_b_r;
    row_nxt   = row_r;
    col_nxt   = col_r;
    k_nxt     = k_r;
    unique case (state_r)
      smasm_pkg::ST_IDLE: begin
        if (accept) begin
          cnt_a_nxt = cnt_a_upd;
          cnt_b_nxt = cnt_b_upd;
          if (cnt_a_upd >= total && cnt_b_upd >= total) begin
            cnt_a_nxt = '0;
            cnt_b_nxt = '0;
            row_nxt   = '0;
            col_nxt   = '0;
            k_nxt     = '0;
            state_nxt = smasm_pkg::ST_RUN;
          end
        end
      end
      smasm_pkg::ST_RUN: begin
        if (k_r != k_end) begin
          k_nxt = k_r + smasm_pkg::POS_W'(1);
        end else begin
          k_nxt = '0;
          if (col_r != last_pos) begin
            col_nxt = col_r + smasm_pkg::POS_W'(1);
          end else begin
            col_nxt = '0;
            if (row_r != last_pos) begin
              row_nxt = row_r + smasm_pkg::POS_W'(1);
            end else begin
              state_nxt = smasm_pkg::ST_DRAIN;
            end
          end
        end
      end
      smasm_pkg::ST_DRAIN: begin
        if (!tag1_r.valid && !tag2_r.valid) begin
          state_nxt = smasm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = smasm_pkg::ST_IDLE;
      end
    endcase
  end

  // Read addresses for the current step of the sequencer.
  assign row_base = row_r * dim_n;
  assign k_base   = k_r * dim_n;
  assign raddr_a  = is_prod ? smasm_pkg::IDX_W'(row_base + 8'(k_r))
                            : smasm_pkg::IDX_W'(row_base + 8'(col_r));
  assign raddr_b  = is_prod ? smasm_pkg::IDX_W'(k_base + 8'(col_r))
                            : smasm_pkg::IDX_W'(row_base + 8'(col_r));

  always_comb begin
    tag0.valid    = (state_r == smasm_pkg::ST_RUN);
    tag0.first    = (k_r == '0);
    tag0.last_k   = (k_r == k_end);
    tag0.last_mat = (k_r == k_end) && (col_r == last_pos) && (row_r == last_pos);
    tag0.row      = row_r;
    tag0.col      = col_r;
  end

  smasm_ram #(
    .WIDTH (smasm_pkg::ELEM_W),
    .DEPTH (smasm_pkg::CELLS)
  ) u_store_a (
    .clk   (clk),
    .we    (we_a),
    .waddr (cnt_a_r[smasm_pkg::IDX_W-1:0]),
    .wdata (in_element_value),
    .raddr (raddr_a),
    .rdata (rdata_a)
  );

  smasm_ram #(
    .WIDTH (smasm_pkg::ELEM_W),
    .DEPTH (smasm_pkg::CELLS)
  ) u_store_b (
    .clk   (clk),
    .we    (we_b),
    .waddr (cnt_b_r[smasm_pkg::IDX_W-1:0]),
    .wdata (in_element_value),
    .raddr (raddr_b),
    .rdata (rdata_b)
  );

  // Shared arithmetic: one multiplier or one adder, then one accumulator.
  assign product  = rdata_a * rdata_b;
  assign sum_diff = is_diff ? ({rdata_a[smasm_pkg::ELEM_W-1], rdata_a}
                               - {rdata_b[smasm_pkg::ELEM_W-1], rdata_b})
                            : ({rdata_a[smasm_pkg::ELEM_W-1], rdata_a}
                               + {rdata_b[smasm_pkg::ELEM_W-1], rdata_b});
  assign term_nxt = is_prod
    ? {product[2*smasm_pkg::ELEM_W-1], product}
    : {{(smasm_pkg::TERM_W-smasm_pkg::ELEM_W-1){sum_diff[smasm_pkg::ELEM_W]}}, sum_diff};

  assign acc_base = tag2_r.first ? '0 : acc_r;
  assign acc_sum  = acc_base
    + {{(smasm_pkg::VAL_W-smasm_pkg::TERM_W){term_r[smasm_pkg::TERM_W-1]}}, term_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= smasm_pkg::ST_IDLE;
      dimension_r  <= smasm_pkg::DIM_RESET;
      mode_r       <= smasm_pkg::MODE_SUM;
      cnt_a_r      <= '0;
      cnt_b_r      <= '0;
      tag1_r       <= '0;
      tag2_r       <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cnt_a_r      <= cnt_a_nxt;
      cnt_b_r      <= cnt_b_nxt;
      tag1_r       <= tag0;
      tag2_r       <= tag1_r;
      out_strobe_r <= tag2_r.valid && tag2_r.last_k;
      if (cfg_we) begin
        unique case (cfg_index)
          smasm_pkg::REG_DIMENSION: dimension_r <= cfg_data;
          smasm_pkg::REG_MODE:      mode_r <= cfg_data[smasm_pkg::MODE_W-1:0];
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    row_r  <= row_nxt;
    col_r  <= col_nxt;
    k_r    <= k_nxt;
    term_r <= term_nxt;
    if (tag2_r.valid) begin
      acc_r <= acc_sum;
      if (tag2_r.last_k) begin
        out_value_r <= acc_sum;
        out_row_r   <= tag2_r.row;
        out_col_r   <= tag2_r.col;
        out_last_r  <= tag2_r.last_mat;
      end
    end
  end

  assign out_strobe         = out_strobe_r;
  assign out_result_value   = out_value_r;
  assign out_result_row     = out_row_r;
  assign out_result_column  = out_col_r;
  assign out_last_of_matrix = out_last_r;

endmodule

// ===== design/smasm_ram.sv =====
// ---------------------------------------------------------------------------
// smasm_ram
// Generic single-write, single-read RAM with a registered read port.
// ---------------------------------------------------------------------------
module smasm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/smasm_checker.sv =====
// ---------------------------------------------------------------------------
// smasm_checker
// Port-level checks on the output pass of the matrix unit, bound to the top.
// ---------------------------------------------------------------------------
`include "square_matrix_add_sub_mul_unit_macros.svh"

module smasm_checker (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_strobe,
  input logic out_last_of_matrix
);

  `SMASM_ASSERT_SAME(a_strobe_while_busy, out_strobe, busy)
  `SMASM_ASSERT_SAME(a_busy_rises_on_start, $rose(busy), $past(start))
  `SMASM_ASSERT_NEXT(a_idle_after_last, out_strobe && out_last_of_matrix, !busy && !out_strobe)
  `SMASM_ASSERT_NEXT(a_busy_until_last, out_strobe && !out_last_of_matrix, busy)
  `SMASM_ASSERT_SAME(a_busy_ends_with_last, $fell(busy), $past(out_strobe && out_last_of_matrix))

endmodule

bind square_matrix_add_sub_mul_unit smasm_checker u_smasm_checker (.*);

// ===== bench/tb.sv =====
// ---------------------------------------------------------------------------
// tb
// Checks the square matrix unit against its own result predictor.
// Words load elements of A and B in row-major order under changing dimension
// and mode settings. Each result word on out_strobe is compared field by field
// with the oldest predicted matrix element; leftover predictions fail the run.
// ---------------------------------------------------------------------------
module tb;

  localparam int SETTLE_CYCLES = 8;
  localparam int RANDOM_WORDS  = 140;
  localparam int REPORT_LIMIT  = 10;

  localparam logic TO_A = 1'b0;
  localparam logic TO_B = 1'b1;

  localparam logic [smasm_pkg::MODE_W-1:0] MODE_PROD_ALT = 2'd3;

  typedef struct packed {
    logic signed [smasm_pkg::VAL_W-1:0] value;
    logic [smasm_pkg::POS_W-1:0]        row;
    logic [smasm_pkg::POS_W-1:0]        column;
    logic                               last;
  } result_word_t;

  logic                                 clk = 1'b0;
  logic                                 rst_n;
  logic                                 start;
  logic                                 busy;
  logic                                 in_target_is_b;
  logic signed [smasm_pkg::ELEM_W-1:0]  in_element_value;
  logic                                 out_strobe;
  logic signed [smasm_pkg::VAL_W-1:0]   out_result_value;
  logic [smasm_pkg::POS_W-1:0]          out_result_row;
  logic [smasm_pkg::POS_W-1:0]          out_result_column;
  logic                                 out_last_of_matrix;
  logic                                 cfg_we;
  logic [smasm_pkg::CFG_IDX_W-1:0]      cfg_index;
  logic [smasm_pkg::CFG_DATA_W-1:0]     cfg_data;

  result_word_t                        expected_cells[$];
  logic signed [smasm_pkg::ELEM_W-1:0] a_cells[smasm_pkg::CELLS];
  logic signed [smasm_pkg::ELEM_W-1:0] b_cells[smasm_pkg::CELLS];
  int unsigned                         a_fill;
  int unsigned                         b_fill;
  logic [smasm_pkg::DIM_W-1:0]         dim_setting;
  logic [smasm_pkg::MODE_W-1:0]        mode_setting;
  bit                                  pass_began;
  bit                                  steady_sender;
  int                                  burst_left;
  int                                  loaded_words;
  int                                  mismatches;

  square_matrix_add_sub_mul_unit i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_target_is_b     (in_target_is_b),
    .in_element_value   (in_element_value),
    .out_strobe         (out_strobe),
    .out_result_value   (out_result_value),
    .out_result_row     (out_result_row),
    .out_result_column  (out_result_column),
    .out_last_of_matrix (out_last_of_matrix),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  always #1 clk = ~clk;

  function automatic int unsigned active_dim();
    if (dim_setting == 0) return 1;
    if (dim_setting > smasm_pkg::MAX_DIM) return smasm_pkg::MAX_DIM;
    return dim_setting;
  endfunction

  function automatic logic signed [smasm_pkg::VAL_W-1:0] cell_result(int unsigned r,
                                                                     int unsigned c,
                                                                     int unsigned n);
    longint acc;
    acc = 0;
    if (mode_setting == smasm_pkg::MODE_SUM) begin
      acc = longint'(a_cells[r*n+c]) + longint'(b_cells[r*n+c]);
    end else if (mode_setting == smasm_pkg::MODE_DIFF) begin
      acc = longint'(a_cells[r*n+c]) - longint'(b_cells[r*n+c]);
    end else begin
      for (int unsigned k = 0; k < n; k++) begin
        acc += longint'(a_cells[r*n+k]) * longint'(b_cells[k*n+c]);
      end
    end
    return acc[smasm_pkg::VAL_W-1:0];
  endfunction

  // Returns whether the element was stored; a full matrix drops it.
  function automatic bit absorb_element(logic target,
                                        logic signed [smasm_pkg::ELEM_W-1:0] v);
    int unsigned  n;
    int unsigned  total;
    bit           stored;
    result_word_t entry;
    n = active_dim();
    total = n * n;
    stored = 0;
    if (target == TO_B) begin
      if (b_fill < total) begin
        b_cells[b_fill] = v;
        b_fill++;
        stored = 1;
      end
    end else begin
      if (a_fill < total) begin
        a_cells[a_fill] = v;
        a_fill++;
        stored = 1;
      end
    end
    if (a_fill >= total && b_fill >= total) begin
      for (int unsigned r = 0; r < n; r++) begin
        for (int unsigned c = 0; c < n; c++) begin
          entry.value  = cell_result(r, c, n);
          entry.row    = smasm_pkg::POS_W'(r);
          entry.column = smasm_pkg::POS_W'(c);
          entry.last   = (r == n - 1) && (c == n - 1);
          expected_cells.push_back(entry);
        end
      end
      a_fill = 0;
      b_fill = 0;
      pass_began = 1;
    end
    return stored;
  endfunction

  function automatic logic signed [smasm_pkg::ELEM_W-1:0] random_element();
    case ($urandom_range(0, 7))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return '0;
      3: return '1;
      default: return smasm_pkg::ELEM_W'($urandom);
    endcase
  endfunction

  function automatic logic [smasm_pkg::DIM_W-1:0] random_dim();
    int unsigned pick;
    pick = $urandom_range(0, 19);
    if (pick == 0) return '0;
    if (pick == 1) return smasm_pkg::DIM_W'($urandom_range(smasm_pkg::MAX_DIM + 1, 15));
    if (pick <= 3) return smasm_pkg::DIM_W'($urandom_range(5, smasm_pkg::MAX_DIM));
    return smasm_pkg::DIM_W'($urandom_range(1, 4));
  endfunction

  function automatic void report_field(string name, longint want, longint got,
                                       result_word_t entry);
    if (want != got) begin
      mismatches++;
      if (mismatches <= REPORT_LIMIT) begin
        $display("result error at row %0d col %0d: %s expected %0d, got %0d",
                 entry.row, entry.column, name, want, got);
      end
    end
  endfunction

  always @(posedge clk) begin
    result_word_t want;
    if (rst_n && out_strobe) begin
      if (expected_cells.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT) begin
          $display("result error: unexpected word value %0d row %0d col %0d",
                   out_result_value, out_result_row, out_result_column);
        end
      end else begin
        want = expected_cells.pop_front();
        report_field("value", want.value, out_result_value, want);
        report_field("row", want.row, out_result_row, want);
        report_field("column", want.column, out_result_column, want);
        report_field("last", want.last, out_last_of_matrix, want);
      end
    end
  end

  task automatic send_word(input logic target,
                           input logic signed [smasm_pkg::ELEM_W-1:0] v);
    int unsigned gap;
    start            <= 1'b1;
    in_target_is_b   <= target;
    in_element_value <= v;
    do @(posedge clk); while (busy);
    if (absorb_element(target, v)) loaded_words++;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if (!steady_sender) begin
        gap = $urandom_range(1, 6);
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    while (expected_cells.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic write_config(input logic [smasm_pkg::DIM_W-1:0] dim,
                              input logic [smasm_pkg::MODE_W-1:0] mode);
    cfg_we    <= 1'b1;
    cfg_index <= smasm_pkg::REG_DIMENSION;
    cfg_data  <= dim;
    @(posedge clk);
    dim_setting = dim;
    cfg_index <= smasm_pkg::REG_MODE;
    cfg_data  <= smasm_pkg::CFG_DATA_W'(mode);
    @(posedge clk);
    mode_setting = mode;
    cfg_we <= 1'b0;
  endtask

  task automatic fill_until_pass();
    int unsigned total;
    logic        target;
    pass_began = 0;
    while (!pass_began) begin
      total = active_dim() * active_dim();
      if (a_fill >= total) target = TO_B;
      else if (b_fill >= total) target = TO_A;
      else target = 1'($urandom_range(0, 1));
      send_word(target, random_element());
    end
  endtask

  task automatic test_reset_settings();
    fill_until_pass();
    wait_idle();
  endtask

  task automatic test_sum_diff_extremes();
    write_config(4'd1, smasm_pkg::MODE_SUM);
    send_word(TO_A, 16'sh7fff);
    send_word(TO_B, 16'sh7fff);
    send_word(TO_B, 16'sh8000);
    send_word(TO_A, 16'sh8000);
    wait_idle();
    // A zero dimension behaves as one.
    write_config(4'd0, smasm_pkg::MODE_DIFF);
    send_word(TO_A, 16'sh7fff);
    send_word(TO_B, 16'sh8000);
    send_word(TO_B, 16'sh7fff);
    send_word(TO_A, 16'sh8000);
    wait_idle();
  endtask

  task automatic test_full_matrix_ignored();
    write_config(4'd2, smasm_pkg::MODE_DIFF);
    repeat (6) send_word(TO_A, random_element());
    repeat (4) send_word(TO_B, random_element());
    wait_idle();
  endtask

  task automatic test_dimension_shrink();
    write_config(4'd3, smasm_pkg::MODE_SUM);
    repeat (5) begin
      send_word(TO_A, random_element());
      send_word(TO_B, random_element());
    end
    wait_idle();
    // Both counts now exceed the smaller matrix, so the next word starts a pass.
    write_config(4'd2, smasm_pkg::MODE_SUM);
    send_word(TO_A, random_element());
    wait_idle();
  endtask

  task automatic test_small_product();
    write_config(4'd2, smasm_pkg::MODE_PROD);
    fill_until_pass();
    wait_idle();
  endtask

  task automatic test_product_extremes();
    // Oversized dimension acts as the largest one, and mode three as the product.
    write_config(4'd15, MODE_PROD_ALT);
    repeat (smasm_pkg::CELLS) send_word(TO_A, 16'sh8000);
    for (int i = 0; i < smasm_pkg::CELLS; i++) begin
      if (i % smasm_pkg::MAX_DIM == 0) send_word(TO_B, 16'sh8000);
      else if (i % smasm_pkg::MAX_DIM == 1) send_word(TO_B, 16'sh7fff);
      else send_word(TO_B, random_element());
    end
    wait_idle();
  endtask

  task automatic test_random_phases();
    int          base;
    int unsigned kind;
    int unsigned total;
    base = loaded_words;
    while (loaded_words - base < RANDOM_WORDS) begin
      steady_sender = ($urandom_range(0, 3) == 0);
      kind = $urandom_range(0, 9);
      if ($urandom_range(0, 1) == 0) begin
        write_config(random_dim(), smasm_pkg::MODE_W'($urandom_range(0, 3)));
      end
      total = active_dim() * active_dim();
      if (kind <= 6) begin
        fill_until_pass();
      end else if (kind == 7) begin
        repeat ($urandom_range(1, 6)) send_word(1'($urandom_range(0, 1)), random_element());
      end else begin
        repeat ($urandom_range(1, 2 * total)) begin
          send_word(1'($urandom_range(0, 1)), random_element());
        end
      end
      wait_idle();
    end
    steady_sender = 0;
  endtask

  initial begin
    rst_n            <= 1'b0;
    start            <= 1'b0;
    in_target_is_b   <= TO_A;
    in_element_value <= '0;
    cfg_we           <= 1'b0;
    cfg_index        <= smasm_pkg::REG_DIMENSION;
    cfg_data         <= '0;
    dim_setting   = smasm_pkg::DIM_RESET;
    mode_setting  = smasm_pkg::MODE_SUM;
    a_fill        = 0;
    b_fill        = 0;
    for (int i = 0; i < smasm_pkg::CELLS; i++) begin
      a_cells[i] = '0;
      b_cells[i] = '0;
    end
    pass_began    = 0;
    steady_sender = 0;
    burst_left    = $urandom_range(1, 12);
    loaded_words  = 0;
    mismatches    = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_settings();
    test_sum_diff_extremes();
    test_full_matrix_ignored();
    test_dimension_shrink();
    test_small_product();
    test_product_extremes();
    test_random_phases();
    wait_idle();
    repeat (16) @(posedge clk);
    if (mismatches == 0 && expected_cells.size() == 0) begin
      $display("square_matrix_add_sub_mul_unit: match");
    end else begin
      $display("square_matrix_add_sub_mul_unit: mismatch");
    end
    $finish;
  end

  initial begin
    #1000000;
    $display("square_matrix_add_sub_mul_unit: mismatch");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+design
design/smasm_pkg.sv
design/smasm_ram.sv
design/square_matrix_add_sub_mul_unit.sv
design/smasm_checker.sv
bench/tb.sv
